>>> hw/rtl/detection_box_decode_filter_macros.svh
// Assertion macros for the detection box decode filter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DETECTION_BOX_DECODE_FILTER_MACROS_SVH
`define DETECTION_BOX_DECODE_FILTER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define DBDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next cycle.
`define DBDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dbdf_pkg.sv
// Package for the detection box decode filter: widths, reset values,
// record positions and register indexes. Depends on nothing.
package dbdf_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned PosW   = 9;
  localparam int unsigned CntW   = 16;
  localparam int unsigned ClassW = 9;
  localparam int unsigned ThrW   = 17;
  localparam int unsigned GainW  = 16;
  localparam int unsigned CcW    = 8;
  localparam int unsigned OutW   = 192;

  localparam logic [PosW-1:0] PosCenterX = 9'd0;
  localparam logic [PosW-1:0] PosCenterY = 9'd1;
  localparam logic [PosW-1:0] PosWidth   = 9'd2;
  localparam logic [PosW-1:0] PosHeight  = 9'd3;
  localparam logic [PosW-1:0] PosObjConf = 9'd4;
  localparam logic [PosW-1:0] PosFirstCl = 9'd5;
  localparam logic [PosW-1:0] PosMax     = 9'd259;

  localparam logic [ValW-1:0]   MinusOneQ16  = 32'hFFFF_0000;
  localparam logic [ClassW-1:0] NoClass      = 9'h1FF;
  localparam logic [CcW-1:0]    ClassCountRst = 8'd80;
  localparam logic [ThrW-1:0]   ThresholdRst = 17'd16384;
  localparam logic [GainW-1:0]  GainRst      = 16'd256;

  typedef enum logic [1:0] {
    RegClassCount = 2'd0,
    RegThreshold  = 2'd1,
    RegGainX      = 2'd2,
    RegGainY      = 2'd3
  } reg_idx_e;

endpackage

>>> hw/rtl/detection_box_decode_filter.sv
// A record's last element passes the stage 1, stage 2 and output registers before it leaves as a result.
// Throughput: one element per cycle; all three stages stall while a result waits on tready.
// Stages: corner sums, then the score and corner products, then shift, saturate, threshold.
// Reset: asynchronous, active low; registers take their reset values, the pipeline empties.
// Top level of the detection box decode filter, with an APB register port.
// Depends on dbdf_pkg and detection_box_decode_filter_macros.svh.
`include "detection_box_decode_filter_macros.svh"

module detection_box_decode_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // Tensor element stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // [31:0] value
  input  logic         s_axis_tuser,  // [0] tensor_start
  // Box stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] left, [63:32] top, [95:64] right, [127:96] bottom,
  // [159:128] box_score, [168:160] class_id, [184:169] box_index, [191:185] zero
  output logic [191:0] m_axis_tdata
);

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [32:0] top;
    top = v[63:31];
    if ((top == 33'h0) || (top == 33'h1_FFFF_FFFF)) begin
      sat32 = v[31:0];
    end else if (v[63]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7FFF_FFFF;
    end
  endfunction

  // Configuration registers
  logic [dbdf_pkg::CcW-1:0]   class_count_q;
  logic [dbdf_pkg::ThrW-1:0]  threshold_q;
  logic [dbdf_pkg::GainW-1:0] gain_x_q;
  logic [dbdf_pkg::GainW-1:0] gain_y_q;
  logic                       cfg_wr;
  dbdf_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = dbdf_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= dbdf_pkg::ClassCountRst;
      threshold_q   <= dbdf_pkg::ThresholdRst;
      gain_x_q      <= dbdf_pkg::GainRst;
      gain_y_q      <= dbdf_pkg::GainRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        dbdf_pkg::RegClassCount: class_count_q <= pwdata[7:0];
        dbdf_pkg::RegThreshold:  threshold_q   <= pwdata[16:0];
        dbdf_pkg::RegGainX:      gain_x_q      <= pwdata[15:0];
        dbdf_pkg::RegGainY:      gain_y_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dbdf_pkg::RegClassCount: prdata = {24'h0, class_count_q};
      dbdf_pkg::RegThreshold:  prdata = {15'h0, threshold_q};
      dbdf_pkg::RegGainX:      prdata = {16'h0, gain_x_q};
      dbdf_pkg::RegGainY:      prdata = {16'h0, gain_y_q};
      default:                 prdata = 32'h0;
    endcase
  end

  // Pipeline control
  logic advance;
  logic in_fire;
  logic out_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_fire       = s_axis_tvalid && advance;

  // Record state
  logic [dbdf_pkg::PosW-1:0]   pos_q, pos_eff, pos_d;
  logic [dbdf_pkg::CntW-1:0]   cnt_q, cnt_eff, cnt_d;
  logic [dbdf_pkg::ValW-1:0]   cx_q, cy_q, w_q, h_q, obj_q;
  logic [dbdf_pkg::ValW-1:0]   best_q, best_eff, best_new, best_d;
  logic [dbdf_pkg::ClassW-1:0] cls_q, cls_eff, cls_new, cls_d;
  logic [dbdf_pkg::ValW-1:0]   obj_new;
  logic                        rec_end;
  logic [dbdf_pkg::ValW-1:0]   v;

  assign v        = s_axis_tdata;
  assign pos_eff  = s_axis_tuser ? dbdf_pkg::PosCenterX : pos_q;
  assign cnt_eff  = s_axis_tuser ? '0 : cnt_q;
  assign best_eff = s_axis_tuser ? dbdf_pkg::MinusOneQ16 : best_q;
  assign cls_eff  = s_axis_tuser ? dbdf_pkg::NoClass : cls_q;
  assign rec_end  = {1'b0, pos_eff} >=
                    ({1'b0, dbdf_pkg::PosObjConf} + {2'b0, class_count_q});

  always_comb begin
    best_new = best_eff;
    cls_new  = cls_eff;
    obj_new  = obj_q;
    if (pos_eff == dbdf_pkg::PosObjConf) begin
      obj_new = v;
    end else if (pos_eff >= dbdf_pkg::PosFirstCl) begin
      if ($signed(v) > $signed(best_eff)) begin
        best_new = v;
        cls_new  = pos_eff - dbdf_pkg::PosFirstCl;
      end
    end
  end

  always_comb begin
    if (rec_end) begin
      pos_d  = dbdf_pkg::PosCenterX;
      cnt_d  = cnt_eff + 1'b1;
      best_d = dbdf_pkg::MinusOneQ16;
      cls_d  = dbdf_pkg::NoClass;
    end else begin
      pos_d  = pos_eff + 1'b1;
      cnt_d  = cnt_eff;
      best_d = best_new;
      cls_d  = cls_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= dbdf_pkg::PosCenterX;
      cnt_q  <= '0;
      cx_q   <= '0;
      cy_q   <= '0;
      w_q    <= '0;
      h_q    <= '0;
      obj_q  <= '0;
      best_q <= dbdf_pkg::MinusOneQ16;
      cls_q  <= dbdf_pkg::NoClass;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      best_q <= best_d;
      cls_q  <= cls_d;
      obj_q  <= obj_new;
      case (pos_eff)
        dbdf_pkg::PosCenterX: cx_q <= v;
        dbdf_pkg::PosCenterY: cy_q <= v;
        dbdf_pkg::PosWidth:   w_q  <= v;
        dbdf_pkg::PosHeight:  h_q  <= v;
        default: ;
      endcase
    end
  end

  // Stage 1: corner coordinates and score operands of a finished record
  logic                        s1_valid_q;
  logic [32:0]                 s1_x1_q, s1_x2_q, s1_y1_q, s1_y2_q;
  logic [dbdf_pkg::ValW-1:0]   s1_obj_q, s1_best_q;
  logic [dbdf_pkg::ClassW-1:0] s1_cls_q;
  logic [dbdf_pkg::CntW-1:0]   s1_idx_q;
  logic [dbdf_pkg::ValW-1:0]   half_w, half_h;

  assign half_w = $signed(w_q) >>> 1;
  assign half_h = $signed(h_q) >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_fire && rec_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_x1_q   <= {cx_q[31], cx_q} - {half_w[31], half_w};
      s1_x2_q   <= {cx_q[31], cx_q} + {half_w[31], half_w};
      s1_y1_q   <= {cy_q[31], cy_q} - {half_h[31], half_h};
      s1_y2_q   <= {cy_q[31], cy_q} + {half_h[31], half_h};
      s1_obj_q  <= obj_new;
      s1_best_q <= best_new;
      s1_cls_q  <= cls_new;
      s1_idx_q  <= cnt_eff;
    end
  end

  // Stage 2: products
  logic                        s2_valid_q;
  logic [49:0]                 s2_x1_q, s2_x2_q, s2_y1_q, s2_y2_q;
  logic [63:0]                 s2_score_q;
  logic [dbdf_pkg::ClassW-1:0] s2_cls_q;
  logic [dbdf_pkg::CntW-1:0]   s2_idx_q;
  logic signed [16:0]          gx_s, gy_s;

  assign gx_s = $signed({1'b0, gain_x_q});
  assign gy_s = $signed({1'b0, gain_y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_x1_q    <= $signed(s1_x1_q) * gx_s;
      s2_x2_q    <= $signed(s1_x2_q) * gx_s;
      s2_y1_q    <= $signed(s1_y1_q) * gy_s;
      s2_y2_q    <= $signed(s1_y2_q) * gy_s;
      s2_score_q <= $signed(s1_obj_q) * $signed(s1_best_q);
      s2_cls_q   <= s1_cls_q;
      s2_idx_q   <= s1_idx_q;
    end
  end

  // Stage 3: shift, saturate, threshold test
  logic [31:0]  score, left, top, right, bottom;
  logic [63:0]  score_sh;
  logic         keep;
  logic [191:0] out_data_q;

  assign score_sh = $signed(s2_score_q) >>> 16;
  assign score    = sat32(score_sh);
  assign left     = sat32(64'($signed(s2_x1_q) >>> 8));
  assign right    = sat32(64'($signed(s2_x2_q) >>> 8));
  assign top      = sat32(64'($signed(s2_y1_q) >>> 8));
  assign bottom   = sat32(64'($signed(s2_y2_q) >>> 8));
  assign keep     = !score[31] && (score[30:0] >= {14'h0, threshold_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {7'h0, s2_idx_q, s2_cls_q, score, bottom, right, top, left};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `DBDF_ASSERT(a_pos_range, pos_q <= dbdf_pkg::PosMax, "record position out of range")
  `DBDF_ASSERT_NEXT(a_cnt_step, in_fire && rec_end, cnt_q == $past(cnt_eff) + 1'b1, "count stuck")
  `DBDF_ASSERT_NEXT(a_s1_load, in_fire && rec_end, s1_valid_q, "finished record not captured")
  `DBDF_ASSERT(a_out_src, $rose(m_axis_tvalid) |-> $past(s2_valid_q), "result without a record")

endmodule

>>> bench/detection_box_decode_filter_tb.sv
`timescale 1ns / 100ps
// Testbench for detection_box_decode_filter: streams tensor elements in random bursts,
// predicts every kept box from the element stream and checks each box transfer field by field.
// Depends on dbdf_pkg and the detection_box_decode_filter RTL.
module detection_box_decode_filter_tb;

  localparam int DrainLimit      = 20000;
  localparam int SettleCycles    = 10;
  localparam int LongStallAt     = 700;
  localparam int LongStallCycles = 300;
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  typedef struct {
    logic [dbdf_pkg::ValW-1:0] value;
    logic                      start;
  } element_t;

  typedef struct {
    logic signed [dbdf_pkg::ValW-1:0]   left, top, right, bottom, score;
    logic signed [dbdf_pkg::ClassW-1:0] class_id;
    logic [dbdf_pkg::CntW-1:0]          box_index;
  } box_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;

  logic [dbdf_pkg::CcW-1:0]   cfg_class_count = dbdf_pkg::ClassCountRst;
  logic [dbdf_pkg::ThrW-1:0]  cfg_threshold = dbdf_pkg::ThresholdRst;
  logic [dbdf_pkg::GainW-1:0] cfg_gain_x = dbdf_pkg::GainRst;
  logic [dbdf_pkg::GainW-1:0] cfg_gain_y = dbdf_pkg::GainRst;

  logic [dbdf_pkg::PosW-1:0]          elem_pos = '0;
  logic [dbdf_pkg::CntW-1:0]          box_count = '0;
  logic signed [dbdf_pkg::ValW-1:0]   cx = '0, cy = '0, bw = '0, bh = '0, obj_conf = '0;
  logic signed [dbdf_pkg::ValW-1:0]   best_val = dbdf_pkg::MinusOneQ16;
  logic signed [dbdf_pkg::ClassW-1:0] best_idx = dbdf_pkg::NoClass;

  element_t element_queue[$];
  box_t     expected_boxes[$];
  int       elems_pushed = 0;
  int       elems_accepted = 0;
  int       errors = 0;
  logic     element_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_mode = 0;
  int       rx_mode_left = 0;
  int       rx_tick = 0;
  int       long_stall_left = 0;
  bit       long_stall_done = 1'b0;

  detection_box_decode_filter uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic signed [dbdf_pkg::ValW-1:0] sat32(input longint v);
    if (v > SatMax) return SatMax[dbdf_pkg::ValW-1:0];
    if (v < SatMin) return SatMin[dbdf_pkg::ValW-1:0];
    return v[dbdf_pkg::ValW-1:0];
  endfunction

  function automatic logic signed [dbdf_pkg::ValW-1:0] scale_corner(
      input longint coord, input logic [dbdf_pkg::GainW-1:0] gain);
    return sat32((coord * longint'(gain)) >>> 8);
  endfunction

  task automatic restart_record();
    elem_pos = '0;
    best_val = dbdf_pkg::MinusOneQ16;
    best_idx = dbdf_pkg::NoClass;
  endtask

  task automatic decode_element(input logic [dbdf_pkg::ValW-1:0] raw, input logic start);
    logic signed [dbdf_pkg::ValW-1:0] v;
    logic signed [dbdf_pkg::ValW-1:0] score;
    int     pos;
    int     cls;
    longint half_w, half_h;
    box_t   box;
    v = raw;
    if (start) begin
      box_count = '0;
      restart_record();
    end
    pos = int'(elem_pos);
    case (elem_pos)
      dbdf_pkg::PosCenterX: cx = v;
      dbdf_pkg::PosCenterY: cy = v;
      dbdf_pkg::PosWidth:   bw = v;
      dbdf_pkg::PosHeight:  bh = v;
      dbdf_pkg::PosObjConf: obj_conf = v;
      default: begin
        if (v > best_val) begin
          best_val = v;
          cls = pos - int'(dbdf_pkg::PosFirstCl);
          best_idx = cls[dbdf_pkg::ClassW-1:0];
        end
      end
    endcase
    if (pos < int'(dbdf_pkg::PosObjConf) + int'(cfg_class_count)) begin
      elem_pos = elem_pos + 1'b1;
      return;
    end
    score = sat32((longint'(obj_conf) * longint'(best_val)) >>> 16);
    box.box_index = box_count;
    box_count = box_count + 1'b1;
    if (longint'(score) < longint'(cfg_threshold)) begin
      restart_record();
      return;
    end
    half_w = longint'(bw) >>> 1;
    half_h = longint'(bh) >>> 1;
    box.left     = scale_corner(longint'(cx) - half_w, cfg_gain_x);
    box.top      = scale_corner(longint'(cy) - half_h, cfg_gain_y);
    box.right    = scale_corner(longint'(cx) + half_w, cfg_gain_x);
    box.bottom   = scale_corner(longint'(cy) + half_h, cfg_gain_y);
    box.score    = score;
    box.class_id = best_idx;
    expected_boxes.insert(expected_boxes.size(), box);
    restart_record();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_box(input logic [191:0] data);
    box_t want;
    if (expected_boxes.size() == 0) begin
      $error("box transfer with no box expected: %h", data);
      errors++;
    end else begin
      want = expected_boxes.pop_front();
      check_field("left", longint'(want.left), longint'($signed(data[31:0])));
      check_field("top", longint'(want.top), longint'($signed(data[63:32])));
      check_field("right", longint'(want.right), longint'($signed(data[95:64])));
      check_field("bottom", longint'(want.bottom), longint'($signed(data[127:96])));
      check_field("box_score", longint'(want.score), longint'($signed(data[159:128])));
      check_field("class_id", longint'(want.class_id), longint'($signed(data[168:160])));
      check_field("box_index", longint'(want.box_index), longint'(data[184:169]));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_element(s_axis_tdata, s_axis_tuser);
        elems_accepted++;
      end
      element_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) check_box(m_axis_tdata);
    end
  end

  // Element driver: random bursts separated by random gaps.
  always @(negedge clk_i) begin
    element_t nxt;
    if (rst_ni && (!s_axis_tvalid || element_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (element_queue.size() != 0) begin
        nxt = element_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.value;
        s_axis_tuser  <= nxt.start;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Box receiver: changing stall patterns, plus one long hold-off that backs up the pipeline.
  always @(negedge clk_i) begin
    if (long_stall_left > 0) begin
      long_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_stall_done && elems_accepted >= LongStallAt && m_axis_tvalid) begin
      long_stall_done = 1'b1;
      long_stall_left = LongStallCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 80);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  task automatic reg_write(input dbdf_pkg::reg_idx_e idx, input logic [31:0] data);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dbdf_pkg::RegClassCount: begin
        cfg_class_count = data[dbdf_pkg::CcW-1:0];
        want = 32'(cfg_class_count);
      end
      dbdf_pkg::RegThreshold: begin
        cfg_threshold = data[dbdf_pkg::ThrW-1:0];
        want = 32'(cfg_threshold);
      end
      dbdf_pkg::RegGainX: begin
        cfg_gain_x = data[dbdf_pkg::GainW-1:0];
        want = 32'(cfg_gain_x);
      end
      default: begin
        cfg_gain_y = data[dbdf_pkg::GainW-1:0];
        want = 32'(cfg_gain_y);
      end
    endcase
    check_field("prdata", longint'(want), longint'(prdata));
  endtask

  task automatic set_config(input logic [dbdf_pkg::CcW-1:0] cc,
                            input logic [dbdf_pkg::ThrW-1:0] thr,
                            input logic [dbdf_pkg::GainW-1:0] gx,
                            input logic [dbdf_pkg::GainW-1:0] gy);
    reg_write(dbdf_pkg::RegClassCount, 32'(cc));
    reg_write(dbdf_pkg::RegThreshold, 32'(thr));
    reg_write(dbdf_pkg::RegGainX, 32'(gx));
    reg_write(dbdf_pkg::RegGainY, 32'(gy));
  endtask

  task automatic push_element(input logic [31:0] value, input logic start);
    element_queue.insert(element_queue.size(), '{value, start});
    elems_pushed++;
  endtask

  // Waits until every element is accepted and every box has arrived, then lets the
  // pipeline settle so that a record still in flight cannot see the next setting.
  task automatic drain();
    int waited;
    waited = 0;
    while ((elems_accepted != elems_pushed || expected_boxes.size() != 0) &&
           waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (elems_accepted != elems_pushed || expected_boxes.size() != 0) begin
      $error("stream did not drain: %0d elements and %0d boxes outstanding",
             elems_pushed - elems_accepted, expected_boxes.size());
      errors++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Geometry is mostly between -320.0 and 960.0, sometimes any value.
  function automatic logic [31:0] coord_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return extreme_value();
      default: return $urandom_range(0, 32'd83886080) - 32'd20971520;
    endcase
  endfunction

  // Confidences are mostly between 0.0 and 1.0, sometimes down to -2.0 or any value.
  function automatic logic [31:0] prob_value();
    case ($urandom_range(0, 19))
      0, 1: return $urandom();
      2: return extreme_value();
      3, 4: return -$urandom_range(0, 131072);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic logic [dbdf_pkg::GainW-1:0] gain_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hFFFF;
      2: return dbdf_pkg::GainRst;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One well-formed record; repeated class scores exercise the first-wins tie rule.
  task automatic push_record(input int n_cls, input logic start);
    logic [31:0] cls_val;
    push_element(coord_value(), start);
    repeat (3) push_element(coord_value(), 1'b0);
    push_element(prob_value(), 1'b0);
    cls_val = prob_value();
    repeat (n_cls) begin
      if ($urandom_range(0, 7) != 0) cls_val = prob_value();
      push_element(cls_val, 1'b0);
    end
  endtask

  initial begin
    int                         p;
    int                         budget;
    int                         phase_base;
    logic [dbdf_pkg::CcW-1:0]   cc;
    logic [dbdf_pkg::ThrW-1:0]  thr;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Saturated score and corners, gains at both extremes, then a new tensor mid-record
    // whose classes never beat -1.0.
    set_config(8'd1, 17'd0, 16'hFFFF, 16'd0);
    push_element(32'h7FFF_FFFF, 1'b1);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h7FFF_FFFF, 1'b0);
    push_element(32'h0001_0000, 1'b0);
    push_element(32'h0002_0000, 1'b0);
    push_element(32'h0001_0000, 1'b1);
    push_element(32'h0001_0000, 1'b0);
    push_element(32'h0002_0000, 1'b0);
    push_element(32'hFFFE_0001, 1'b0);
    push_element(32'hFFFF_0000, 1'b0);
    push_element(32'h8000_0000, 1'b0);
    drain();

    // No class scores: the record ends at the confidence, kept exactly at the threshold.
    set_config(8'd0, 17'd65536, dbdf_pkg::GainRst, dbdf_pkg::GainRst);
    push_element(32'h0010_0000, 1'b0);
    push_element(32'h0020_0000, 1'b0);
    push_element(32'h0004_0000, 1'b0);
    push_element(32'h0003_0000, 1'b0);
    push_element(32'hFFFF_0000, 1'b0);
    drain();

    // Tied class scores, then a record left open past the end of the next, lower count.
    set_config(8'd2, 17'd0, dbdf_pkg::GainRst, dbdf_pkg::GainRst);
    push_element(32'h0040_0000, 1'b1);
    push_element(32'h0030_0000, 1'b0);
    push_element(32'h0008_0000, 1'b0);
    push_element(32'h0006_0000, 1'b0);
    push_element(32'h0001_0000, 1'b0);
    push_element(32'h0000_8000, 1'b0);
    push_element(32'h0000_8000, 1'b0);
    repeat (5) push_element(prob_value(), 1'b0);
    drain();

    for (p = 0; p < 13; p++) begin
      case (p)
        0: cc = 8'd0;
        1: cc = 8'd80;
        2: cc = 8'd255;
        default: cc = 8'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = 17'd65536;
        2: thr = dbdf_pkg::ThresholdRst;
        default: thr = 17'($urandom_range(0, 65536));
      endcase
      set_config(cc, thr, gain_value(), gain_value());
      if (p == 0) push_element(prob_value(), 1'b0);
      budget = (p == 1 || p == 2) ? 1 : 62;
      phase_base = elems_pushed;
      push_record(int'(cc), 1'b1);
      while (elems_pushed - phase_base < budget) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, int'(cc) + 4)) push_element(prob_value(), 1'b0);
            push_record(int'(cc), 1'b1);
          end
          1: push_record(int'(cc), 1'b1);
          default: push_record(int'(cc), 1'b0);
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS detection_box_decode_filter");
    end else begin
      $display("FAIL detection_box_decode_filter");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL detection_box_decode_filter");
    $finish;
  end

endmodule
